// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RSC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define RSC_ASSERT(lbl, clk, rstn, prop, msg)
`define RSC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: sv/rsc_pkg.sv
// ---------------------------------------------------------------------------
// rsc_pkg
// Types and codes shared by the RPN calculator modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rsc_pkg;

  localparam logic [3:0] FN_PUSH  = 4'd0;
  localparam logic [3:0] FN_ADD   = 4'd1;
  localparam logic [3:0] FN_SUB   = 4'd2;
  localparam logic [3:0] FN_MUL   = 4'd3;
  localparam logic [3:0] FN_DIV   = 4'd4;
  localparam logic [3:0] FN_MOD   = 4'd5;
  localparam logic [3:0] FN_STORE = 4'd6;
  localparam logic [3:0] FN_LOAD  = 4'd7;
  localparam logic [3:0] FN_DUP   = 4'd8;
  localparam logic [3:0] FN_SWAP  = 4'd9;
  localparam logic [3:0] FN_CLEAR = 4'd10;
  localparam logic [3:0] FN_POP   = 4'd11;
  localparam logic [3:0] FN_SHOW  = 4'd12;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_ZDIV  = 3'd3;
  localparam logic [2:0] ST_UNSET = 3'd4;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] operand_value;
    logic [4:0]         var_index;
  } rsc_cmd_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic [6:0]         depth;
    logic               last;
  } rsc_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDB, S_RDA, S_DEC, S_MUL, S_DIVGO, S_DIVW, S_WRES,
    S_CRD, S_CWR, S_SRD, S_SEM, S_SW1, S_SW2
  } state_e;

  typedef enum logic [1:0] {RD_TOP, RD_SEC, RD_SRC} rd_sel_e;
  typedef enum logic [2:0] {
    WR_NONE, WR_PUSH, WR_LOAD, WR_RES, WR_SWAP_TOP, WR_SWAP_SEC, WR_COPY
  } wr_sel_e;
  typedef enum logic [2:0] {SP_HOLD, SP_INC, SP_DEC, SP_CLR, SP_DUP} sp_op_e;
  typedef enum logic [1:0] {EM_NONE, EM_ACK, EM_VAL, EM_ELEM} emit_e;

  typedef struct packed {
    logic       latch_cmd;
    rd_sel_e    rd_sel;
    logic       cap_b;
    logic       cap_a;
    wr_sel_e    wr_sel;
    sp_op_e     sp_op;
    logic       var_wr;
    logic       mul_cap;
    logic       div_start;
    logic       setup_n;
    logic       idx_inc;
    emit_e      emit;
    logic [2:0] status;
  } ctrl_t;

  typedef struct packed {
    logic [3:0] func;
    logic       sp_lt1;
    logic       sp_lt2;
    logic       sp_full;
    logic       vi_bad;
    logic       var_bad;
    logic       b_zero;
    logic       ib_zero;
    logic       dup_full;
    logic       idx_done;
    logic       idx_last;
    logic       div_done;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: sv/rpn_stack_calculator_top.sv
// ---------------------------------------------------------------------------
// rpn_stack_calculator_top
// Reverse-Polish fixed-point calculator: sequencer plus datapath.
// ---------------------------------------------------------------------------
//   channel  | ports                     | handshake
//   ---------+---------------------------+------------------------------------
//   command  | start, busy, cmd_i        | item taken when start && !busy
//   result   | res_valid_o, res_o        | one-cycle strobe, no back-pressure
//
// Every command reads the top two stack entries before it is decoded; add/sub then
// write their result, mul first captures the product. div/mod run the shared
// restoring divider over 32+FRACTION_BITS quotient bits (Q16.16 by default). dup and
// show handle one element at a time through the single read port of the stack memory.
// Reset clears the stack pointer, variable valid bits and the sequencer, not the
// memories. Results cannot be stalled; busy stays high until the last result is issued.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rpn_stack_calculator_top
  import rsc_pkg::*;
#(
  parameter int STACK_DEPTH   = 64,
  parameter int NUM_VARIABLES = 26,
  parameter int FRACTION_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  rsc_cmd_t cmd_i,
  output rsc_res_t res_o,
  output logic     res_valid_o
);
  ctrl_t ctrl;
  stat_t stat;

  // sequencer: one state machine walks each command
  rsc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  // datapath: stack, variables, arithmetic, result register
  rsc_dp #(
    .STACK_DEPTH  (STACK_DEPTH),
    .NUM_VARIABLES(NUM_VARIABLES),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  `RSC_ASSERT(a_res_after_busy, clk_i, rst_ni, res_valid_o |-> $past(busy), "result without work")
  `RSC_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accept did not start")
  `RSC_ASSERT_NEVER(a_idle_write, clk_i, rst_ni, !busy && ctrl.wr_sel != WR_NONE, "idle write")
  `RSC_ASSERT(a_depth_max, clk_i, rst_ni, res_valid_o |-> res_o.depth <= 7'(STACK_DEPTH), "depth")
endmodule

// File: sv/rsc_div.sv
// ---------------------------------------------------------------------------
// rsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rsc_div #(
  parameter int DVW = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [31:0]    divisor_i,
  output logic [DVW-1:0] quot_o,
  output logic [31:0]    rem_o,
  output logic           done_o
);
  localparam int CW = $clog2(DVW + 1);

  logic          run_q;
  logic [CW-1:0] cnt_q;
  logic [DVW-1:0] dvd_q;
  logic [31:0]   rem_q, dsr_q;
  logic [32:0]   rem_sh, rem_sub;
  logic          ge;

  assign rem_sh  = {rem_q, dvd_q[DVW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CW'(DVW);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
      dvd_q <= {dvd_q[DVW-2:0], ge};
    end
  end

  assign quot_o = dvd_q;
  assign rem_o  = rem_q;
  assign done_o = !run_q;
endmodule

// File: sv/rsc_dp.sv
// ---------------------------------------------------------------------------
// rsc_dp
// Datapath: stack memory, variables, pointer, arithmetic and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rsc_dp
  import rsc_pkg::*;
#(
  parameter int STACK_DEPTH   = 64,
  parameter int NUM_VARIABLES = 26,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rsc_cmd_t  cmd_i,
  input  ctrl_t     ctrl_i,
  output stat_t     stat_o,
  output rsc_res_t  res_o,
  output logic      res_valid_o
);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int VIW = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
  localparam int DVW = 32 + FRACTION_BITS;

  rsc_cmd_t cmd_q;
  logic [SPW-1:0] sp_q, sp_d, sp_m1, sp_m2;
  logic [SPW-1:0] start_q, cnt_q, i_q, start_n, cnt_n;
  logic signed [31:0] mem [STACK_DEPTH];
  logic signed [31:0] vmem [NUM_VARIABLES];
  logic [NUM_VARIABLES-1:0] vvalid_q;
  logic signed [31:0] rdata_q, vdata_q, a_q, b_q, wdata, res;
  logic signed [63:0] prod_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [VIW-1:0] vi;
  logic [31:0] a_mag, b_mag, a_int, b_int, rem;
  logic [DVW-1:0] quot, dvd;
  logic div_done;
  logic signed [63:0] q64, r64;
  rsc_res_t res_q;
  logic res_valid_q;

  assign sp_m1 = sp_q - 1'b1;
  assign sp_m2 = sp_q - SPW'(2);
  assign vi    = cmd_q.var_index[VIW-1:0];

  assign a_mag = a_q[31] ? (~a_q + 1'b1) : a_q;
  assign b_mag = b_q[31] ? (~b_q + 1'b1) : b_q;
  assign a_int = a_mag >> FRACTION_BITS;
  assign b_int = b_mag >> FRACTION_BITS;

  // dup/show window from popped n
  always_comb begin
    if ((b_q[31] && b_int != '0) || b_int > 32'(sp_m1)) start_n = '0;
    else start_n = sp_m1 - b_int[SPW-1:0];
    cnt_n = sp_m1 - start_n;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_cmd) cmd_q <= cmd_i;
  end

  // stack memory, one read and one write port
  always_comb begin
    case (ctrl_i.rd_sel)
      RD_SEC:  rd_addr = sp_m2[AW-1:0];
      RD_SRC:  rd_addr = AW'(start_q + i_q);
      default: rd_addr = sp_m1[AW-1:0];
    endcase
  end

  always_comb begin
    wr_addr = sp_q[AW-1:0];
    wdata   = cmd_q.operand_value;
    case (ctrl_i.wr_sel)
      WR_LOAD:     wdata = vdata_q;
      WR_RES: begin
        wr_addr = sp_m2[AW-1:0];
        wdata   = res;
      end
      WR_SWAP_TOP: begin
        wr_addr = sp_m1[AW-1:0];
        wdata   = a_q;
      end
      WR_SWAP_SEC: begin
        wr_addr = sp_m2[AW-1:0];
        wdata   = b_q;
      end
      WR_COPY: begin
        wr_addr = AW'(sp_m1 + i_q);
        wdata   = rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_sel != WR_NONE) mem[wr_addr] <= wdata;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.var_wr) vmem[vi] <= b_q;
    vdata_q <= vmem[vi];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vvalid_q <= '0;
    else if (ctrl_i.var_wr) vvalid_q[vi] <= 1'b1;
  end

  always_comb begin
    case (ctrl_i.sp_op)
      SP_INC:  sp_d = sp_q + 1'b1;
      SP_DEC:  sp_d = sp_m1;
      SP_CLR:  sp_d = '0;
      SP_DUP:  sp_d = sp_m1 + cnt_q;
      default: sp_d = sp_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sp_q <= '0;
    else sp_q <= sp_d;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_b) b_q <= rdata_q;
    if (ctrl_i.cap_a) a_q <= rdata_q;
    if (ctrl_i.mul_cap) prod_q <= 64'(a_q) * 64'(b_q);
    if (ctrl_i.setup_n) begin
      start_q <= start_n;
      cnt_q   <= cnt_n;
      i_q     <= '0;
    end else if (ctrl_i.idx_inc) begin
      i_q <= i_q + 1'b1;
    end
  end

  assign dvd = (cmd_q.func == FN_DIV) ? (DVW'(a_mag) << FRACTION_BITS) : DVW'(a_int);

  rsc_div #(.DVW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (dvd),
    .divisor_i  ((cmd_q.func == FN_DIV) ? b_mag : b_int),
    .quot_o     (quot),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  always_comb begin
    q64 = (a_q[31] ^ b_q[31]) ? -$signed(64'(quot)) : $signed(64'(quot));
    r64 = $signed(64'(rem) << FRACTION_BITS);
    if (a_q[31]) r64 = -r64;
    case (cmd_q.func)
      FN_ADD:  res = sat32(64'(a_q) + 64'(b_q));
      FN_SUB:  res = sat32(64'(a_q) - 64'(b_q));
      FN_MUL:  res = sat32(prod_q >>> FRACTION_BITS);
      FN_DIV:  res = sat32(q64);
      default: res = sat32(r64);
    endcase
  end

  always_comb begin
    stat_o.func     = cmd_q.func;
    stat_o.sp_lt1   = sp_q == '0;
    stat_o.sp_lt2   = sp_q < SPW'(2);
    stat_o.sp_full  = sp_q == SPW'(STACK_DEPTH);
    stat_o.vi_bad   = cmd_q.var_index >= 5'(NUM_VARIABLES);
    stat_o.var_bad  = stat_o.vi_bad || !vvalid_q[vi];
    stat_o.b_zero   = b_q == '0;
    stat_o.ib_zero  = b_int == '0;
    stat_o.dup_full = ({1'b0, sp_m1} + {1'b0, cnt_n}) > (SPW + 1)'(STACK_DEPTH);
    stat_o.idx_done = i_q == cnt_q;
    stat_o.idx_last = i_q == (cnt_q - 1'b1);
    stat_o.div_done = div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else res_valid_q <= ctrl_i.emit != EM_NONE;
  end

  always_ff @(posedge clk_i) begin
    res_q.depth <= 7'(sp_d);
    case (ctrl_i.emit)
      EM_VAL: begin
        res_q.value  <= b_q;
        res_q.status <= ST_OK;
        res_q.last   <= 1'b1;
      end
      EM_ELEM: begin
        res_q.value  <= rdata_q;
        res_q.status <= ST_OK;
        res_q.last   <= stat_o.idx_last;
      end
      default: begin
        res_q.value  <= '0;
        res_q.status <= ctrl_i.status;
        res_q.last   <= 1'b1;
      end
    endcase
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;
endmodule

// File: sv/rsc_ctrl.sv
// ---------------------------------------------------------------------------
// rsc_ctrl
// Command sequencer driving the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rsc_ctrl
  import rsc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = state_q != S_IDLE;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_i) state_d = S_RDB;
      S_RDB:   state_d = S_RDA;
      S_RDA:   state_d = S_DEC;
      S_DEC: begin
        state_d = S_IDLE;
        unique case (stat_i.func) inside
          FN_ADD, FN_SUB: if (!stat_i.sp_lt2) state_d = S_WRES;
          FN_MUL:         if (!stat_i.sp_lt2) state_d = S_MUL;
          FN_DIV:         if (!stat_i.sp_lt2 && !stat_i.b_zero) state_d = S_DIVGO;
          FN_MOD:         if (!stat_i.sp_lt2 && !stat_i.ib_zero) state_d = S_DIVGO;
          FN_DUP:         if (!stat_i.sp_lt1 && !stat_i.dup_full) state_d = S_CRD;
          FN_SHOW:        if (!stat_i.sp_lt1) state_d = S_SRD;
          FN_SWAP:        if (!stat_i.sp_lt2) state_d = S_SW1;
          default: ;
        endcase
      end
      S_MUL:   state_d = S_WRES;
      S_DIVGO: state_d = S_DIVW;
      S_DIVW:  if (stat_i.div_done) state_d = S_WRES;
      S_WRES:  state_d = S_IDLE;
      S_CRD:   state_d = stat_i.idx_done ? S_IDLE : S_CWR;
      S_CWR:   state_d = S_CRD;
      S_SRD:   state_d = stat_i.idx_done ? S_IDLE : S_SEM;
      S_SEM:   state_d = stat_i.idx_last ? S_IDLE : S_SRD;
      S_SW1:   state_d = S_SW2;
      S_SW2:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o.latch_cmd = 1'b0;
    ctrl_o.rd_sel    = RD_TOP;
    ctrl_o.cap_b     = 1'b0;
    ctrl_o.cap_a     = 1'b0;
    ctrl_o.wr_sel    = WR_NONE;
    ctrl_o.sp_op     = SP_HOLD;
    ctrl_o.var_wr    = 1'b0;
    ctrl_o.mul_cap   = 1'b0;
    ctrl_o.div_start = 1'b0;
    ctrl_o.setup_n   = 1'b0;
    ctrl_o.idx_inc   = 1'b0;
    ctrl_o.emit      = EM_NONE;
    ctrl_o.status    = ST_OK;
    unique case (state_q)
      S_IDLE: ctrl_o.latch_cmd = start_i;
      S_RDB:  ctrl_o.rd_sel = RD_TOP;
      S_RDA: begin
        ctrl_o.cap_b  = 1'b1;
        ctrl_o.rd_sel = RD_SEC;
      end
      S_DEC: begin
        ctrl_o.cap_a = 1'b1;
        ctrl_o.emit  = EM_ACK;
        unique case (stat_i.func) inside
          FN_PUSH: begin
            if (stat_i.sp_full) ctrl_o.status = ST_FULL;
            else begin
              ctrl_o.wr_sel = WR_PUSH;
              ctrl_o.sp_op  = SP_INC;
            end
          end
          FN_ADD, FN_SUB, FN_MUL, FN_SWAP: begin
            if (stat_i.sp_lt2) ctrl_o.status = ST_EMPTY;
            else ctrl_o.emit = EM_NONE;
          end
          FN_DIV: begin
            if (stat_i.sp_lt2) ctrl_o.status = ST_EMPTY;
            else if (stat_i.b_zero) ctrl_o.status = ST_ZDIV;
            else ctrl_o.emit = EM_NONE;
          end
          FN_MOD: begin
            if (stat_i.sp_lt2) ctrl_o.status = ST_EMPTY;
            else if (stat_i.ib_zero) ctrl_o.status = ST_ZDIV;
            else ctrl_o.emit = EM_NONE;
          end
          FN_STORE: begin
            if (stat_i.sp_lt1) ctrl_o.status = ST_EMPTY;
            else if (stat_i.vi_bad) ctrl_o.status = ST_UNSET;
            else begin
              ctrl_o.var_wr = 1'b1;
              ctrl_o.sp_op  = SP_DEC;
            end
          end
          FN_LOAD: begin
            if (stat_i.var_bad) ctrl_o.status = ST_UNSET;
            else if (stat_i.sp_full) ctrl_o.status = ST_FULL;
            else begin
              ctrl_o.wr_sel = WR_LOAD;
              ctrl_o.sp_op  = SP_INC;
            end
          end
          FN_DUP: begin
            if (stat_i.sp_lt1) ctrl_o.status = ST_EMPTY;
            else if (stat_i.dup_full) ctrl_o.status = ST_FULL;
            else begin
              ctrl_o.emit    = EM_NONE;
              ctrl_o.setup_n = 1'b1;
            end
          end
          FN_SHOW: begin
            if (stat_i.sp_lt1) ctrl_o.status = ST_EMPTY;
            else begin
              ctrl_o.emit    = EM_NONE;
              ctrl_o.setup_n = 1'b1;
              ctrl_o.sp_op   = SP_DEC;
            end
          end
          FN_CLEAR: ctrl_o.sp_op = SP_CLR;
          FN_POP: begin
            if (stat_i.sp_lt1) ctrl_o.status = ST_EMPTY;
            else begin
              ctrl_o.emit  = EM_VAL;
              ctrl_o.sp_op = SP_DEC;
            end
          end
          default: ;
        endcase
      end
      S_MUL:   ctrl_o.mul_cap = 1'b1;
      S_DIVGO: ctrl_o.div_start = 1'b1;
      S_DIVW:  ;
      S_WRES: begin
        ctrl_o.wr_sel = WR_RES;
        ctrl_o.sp_op  = SP_DEC;
        ctrl_o.emit   = EM_ACK;
      end
      S_CRD: begin
        ctrl_o.rd_sel = RD_SRC;
        if (stat_i.idx_done) begin
          ctrl_o.sp_op = SP_DUP;
          ctrl_o.emit  = EM_ACK;
        end
      end
      S_CWR: begin
        ctrl_o.wr_sel  = WR_COPY;
        ctrl_o.idx_inc = 1'b1;
      end
      S_SRD: begin
        ctrl_o.rd_sel = RD_SRC;
        if (stat_i.idx_done) ctrl_o.emit = EM_ACK;
      end
      S_SEM: begin
        ctrl_o.emit    = EM_ELEM;
        ctrl_o.idx_inc = 1'b1;
      end
      S_SW1: ctrl_o.wr_sel = WR_SWAP_TOP;
      S_SW2: begin
        ctrl_o.wr_sel = WR_SWAP_SEC;
        ctrl_o.emit   = EM_ACK;
      end
      default: ;
    endcase
  end
endmodule
